FILE: src/flac_pkg.sv
package flac_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_BITS     = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_ZERO  = 2'd3;

  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [ADDR_BITS-1:0] region_start;
    logic [ADDR_BITS-1:0] region_size;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] granted_start;
    logic [CNT_W-1:0]     entries_used;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } entry_t;

endpackage

FILE: src/free_list_allocator_coalescing_unit.sv
// Free-region allocator with merging on release. Pulse start with busy low to hand in one
// request beat (allocate or free); exactly one response beat follows on out_valid for a single
// cycle, and the receiver cannot stall it, so it must sample out_rsp whenever out_valid is high.
// A request of nonzero size walks all sixteen entries of its region table through one
// synchronous memory read port, then writes back the chosen entry in the update state, and
// the response is registered at the end of that state. A zero-size request skips the scan
// and goes straight to the update state. busy drops in the cycle the response appears, so a
// new request can be taken while the response beat is on the ports.
module free_list_allocator_coalescing_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  flac_pkg::req_t   in_req,
  output logic             out_valid,
  output flac_pkg::rsp_t   out_rsp,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  localparam int AW = flac_pkg::ADDR_BITS;
  localparam int IW = flac_pkg::IDX_W;
  localparam int CW = flac_pkg::CNT_W;
  localparam int NE = flac_pkg::TABLE_ENTRIES;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  localparam logic [AW-1:0] LEN_MAX = {AW{1'b1}};
  localparam logic [CW-1:0] SCAN_END = CW'(NE);

  // Control state.
  logic [1:0]    state_r, state_nxt;
  logic          fit_mode_r;
  logic [NE-1:0] valid_r;
  logic [CW-1:0] used_r;
  logic [CW-1:0] scan_r;

  // The request being served.
  flac_pkg::req_t req_r;

  // Region table: one synchronous memory, start and length side by side.
  flac_pkg::entry_t mem [NE];
  flac_pkg::entry_t rd_data_r;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             ev_vld_r;
  logic [IW-1:0]    ev_idx_r;

  // Search trackers, filled while the table streams past.
  logic          pick_found_r;
  logic [IW-1:0] pick_idx_r;
  logic [AW-1:0] pick_start_r;
  logic [AW-1:0] pick_len_r;
  logic          below_found_r;
  logic [IW-1:0] below_idx_r;
  logic [AW-1:0] below_len_r;
  logic          above_found_r;
  logic [IW-1:0] above_idx_r;
  logic [AW-1:0] above_len_r;
  logic          slot_found_r;
  logic [IW-1:0] slot_idx_r;

  logic accept;
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req.region_size == '0) ? ST_UPD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_r == SCAN_END) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read side of the scan: one address per cycle, with the read data registered.
  assign rd_en   = (state_r == ST_SCAN) && (scan_r != SCAN_END);
  assign rd_addr = scan_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    ev_idx_r <= rd_addr;
  end

  // Per-entry evaluation of the beat that just came out of the memory.
  logic          ev_valid;
  logic          ev_fits;
  logic          ev_better;
  logic          ev_below;
  logic          ev_above;
  logic [AW:0]   ev_end;
  logic [AW:0]   req_end;

  always_comb begin
    ev_valid = valid_r[ev_idx_r];
    ev_end   = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.len};
    req_end  = {1'b0, req_r.region_start} + {1'b0, req_r.region_size};
    ev_fits  = ev_valid && (rd_data_r.len >= req_r.region_size);
    if (!pick_found_r) begin
      ev_better = 1'b1;
    end else if (fit_mode_r == flac_pkg::FIT_FIRST) begin
      ev_better = rd_data_r.start < pick_start_r;
    end else begin
      ev_better = (rd_data_r.len < pick_len_r) ||
                  ((rd_data_r.len == pick_len_r) && (rd_data_r.start < pick_start_r));
    end
    ev_below = ev_valid && !below_found_r && (ev_end == {1'b0, req_r.region_start});
    ev_above = ev_valid && !above_found_r && ({1'b0, rd_data_r.start} == req_end);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (ev_vld_r) begin
      if (req_r.func == flac_pkg::FUNC_ALLOC) begin
        if (ev_fits && ev_better) begin
          pick_idx_r   <= ev_idx_r;
          pick_start_r <= rd_data_r.start;
          pick_len_r   <= rd_data_r.len;
        end
      end else begin
        if (ev_below) begin
          below_idx_r <= ev_idx_r;
          below_len_r <= rd_data_r.len;
        end
        if (ev_above) begin
          above_idx_r <= ev_idx_r;
          above_len_r <= rd_data_r.len;
        end
        if (!ev_valid && !slot_found_r) begin
          slot_idx_r <= ev_idx_r;
        end
      end
    end
  end

  // Write-back decision, taken in the update cycle.
  logic             wr_en;
  logic [IW-1:0]    wr_idx;
  flac_pkg::entry_t wr_ent;
  logic             set_vld;
  logic             clr_vld;
  logic [IW-1:0]    clr_idx;
  logic [1:0]       upd_status;
  logic [AW-1:0]    upd_grant;
  logic [AW+1:0]    merge_sum;
  logic [AW-1:0]    merge_len;
  logic [AW-1:0]    left_len;

  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = slot_idx_r;
    wr_ent     = '{start: req_r.region_start, len: req_r.region_size};
    set_vld    = 1'b0;
    clr_vld    = 1'b0;
    clr_idx    = pick_idx_r;
    upd_status = flac_pkg::STAT_OK;
    upd_grant  = '0;
    left_len   = pick_len_r - req_r.region_size;

    merge_sum = {2'b00, req_r.region_size};
    if (below_found_r) begin
      merge_sum = merge_sum + {2'b00, below_len_r};
    end
    if (above_found_r) begin
      merge_sum = merge_sum + {2'b00, above_len_r};
    end
    merge_len = (merge_sum > {2'b00, LEN_MAX}) ? LEN_MAX : merge_sum[AW-1:0];

    if (req_r.region_size == '0) begin
      upd_status = flac_pkg::STAT_ZERO;
    end else if (req_r.func == flac_pkg::FUNC_ALLOC) begin
      if (pick_found_r) begin
        wr_en     = 1'b1;
        wr_idx    = pick_idx_r;
        wr_ent    = '{start: pick_start_r + req_r.region_size, len: left_len};
        upd_grant = pick_start_r;
        clr_vld   = (left_len == '0);
        clr_idx   = pick_idx_r;
      end else begin
        upd_status = flac_pkg::STAT_NOFIT;
      end
    end else begin
      priority if (below_found_r) begin
        // Grow the region below; an adjacent region above is absorbed and dropped.
        wr_en   = 1'b1;
        wr_idx  = below_idx_r;
        wr_ent  = '{start: pick_start_r, len: merge_len};
        clr_vld = above_found_r;
        clr_idx = above_idx_r;
      end else if (above_found_r) begin
        wr_en  = 1'b1;
        wr_idx = above_idx_r;
        wr_ent = '{start: req_r.region_start, len: merge_len};
      end else if (slot_found_r) begin
        wr_en   = 1'b1;
        wr_idx  = slot_idx_r;
        set_vld = 1'b1;
      end else begin
        upd_status = flac_pkg::STAT_FULL;
      end
    end
  end

  // The below-merge keeps the old start: the write mask on the start half leaves the stored start
  // unwritten, so only the length of that entry is updated.
  logic wr_keep_start;
  assign wr_keep_start = (req_r.func == flac_pkg::FUNC_FREE) && below_found_r;

  always_ff @(posedge clk) begin
    if ((state_r == ST_UPD) && wr_en) begin
      if (!wr_keep_start) begin
        mem[wr_idx].start <= wr_ent.start;
      end
      mem[wr_idx].len <= wr_ent.len;
    end
  end

  logic [CW-1:0] used_nxt;
  always_comb begin
    used_nxt = used_r;
    if (set_vld) begin
      used_nxt = used_r + CW'(1);
    end else if (clr_vld) begin
      used_nxt = used_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fit_mode_r    <= flac_pkg::FIT_FIRST;
      valid_r       <= '0;
      used_r        <= '0;
      scan_r        <= '0;
      ev_vld_r      <= 1'b0;
      pick_found_r  <= 1'b0;
      below_found_r <= 1'b0;
      above_found_r <= 1'b0;
      slot_found_r  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= rd_en;
      if (cfg_we) begin
        fit_mode_r <= cfg_wdata;
      end
      if (accept) begin
        scan_r        <= '0;
        pick_found_r  <= 1'b0;
        below_found_r <= 1'b0;
        above_found_r <= 1'b0;
        slot_found_r  <= 1'b0;
      end else if (rd_en) begin
        scan_r <= scan_r + CW'(1);
      end
      if (ev_vld_r) begin
        if (req_r.func == flac_pkg::FUNC_ALLOC) begin
          if (ev_fits) begin
            pick_found_r <= 1'b1;
          end
        end else begin
          if (ev_below) begin
            below_found_r <= 1'b1;
          end
          if (ev_above) begin
            above_found_r <= 1'b1;
          end
          if (!ev_valid) begin
            slot_found_r <= 1'b1;
          end
        end
      end
      out_valid <= (state_r == ST_UPD);
      if (state_r == ST_UPD) begin
        used_r <= used_nxt;
        if (set_vld) begin
          valid_r[wr_idx] <= 1'b1;
        end
        if (clr_vld) begin
          valid_r[clr_idx] <= 1'b0;
        end
      end
    end
  end

  // Response beat, registered at the end of the update cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      out_rsp.status        <= upd_status;
      out_rsp.granted_start <= upd_grant;
      out_rsp.entries_used  <= used_nxt;
    end
  end

endmodule
